>>> rtl/isq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Sizes, operation codes and status codes shared by the store and its checker.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = 5;
    localparam int VW    = 32;
    localparam int FW    = 3;
    localparam int SW    = 2;
    localparam int XW    = (CW > PW) ? CW : PW;

    localparam logic [FW-1:0] FN_PUSH_BACK  = 3'd0;
    localparam logic [FW-1:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [FW-1:0] FN_POP_BACK   = 3'd2;
    localparam logic [FW-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FW-1:0] FN_INSERT     = 3'd4;
    localparam logic [FW-1:0] FN_REMOVE_AT  = 3'd5;
    localparam logic [FW-1:0] FN_REMOVE_VAL = 3'd6;

    localparam logic [SW-1:0] ST_DONE    = 2'd0;
    localparam logic [SW-1:0] ST_IGNORED = 2'd1;
    localparam logic [SW-1:0] ST_FULL    = 2'd2;

endpackage

>>> rtl/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// Indexed sequence store
// Bounded deque with positional insert and remove, held in a single-port
// register memory and reordered one entry at a time by a small sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and busy then stays
// high until the cycle in which the result is shown. After decode, a push or
// insert that goes in reads and writes every entry that it moves and then
// writes the new item, a remove reads and writes every entry that it moves,
// and a remove by value first reads and compares entries from the front;
// every item then reads the front and back values before its result shows.
// The memory is read or written one entry per cycle, so moving one entry
// costs a read and a write. The result appears for exactly one cycle with
// o_valid high, and the receiver cannot stall it. Front and back values are
// zero when the count is zero.
module indexed_sequence_store
    import isq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FW-1:0]        i_func,
    input  logic [PW-1:0]        i_position,
    input  logic signed [VW-1:0] i_item_value,
    output logic                 o_valid,
    output logic [SW-1:0]        o_status,
    output logic [CW-1:0]        o_count,
    output logic signed [VW-1:0] o_front_value,
    output logic signed [VW-1:0] o_back_value
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_PUT_RD   = 4'd2;
    localparam logic [3:0] S_PUT_WR   = 4'd3;
    localparam logic [3:0] S_PUT_LAST = 4'd4;
    localparam logic [3:0] S_TAKE_RD  = 4'd5;
    localparam logic [3:0] S_TAKE_WR  = 4'd6;
    localparam logic [3:0] S_FIND_RD  = 4'd7;
    localparam logic [3:0] S_FIND_CMP = 4'd8;
    localparam logic [3:0] S_FRONT_RD = 4'd9;
    localparam logic [3:0] S_BACK_RD  = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [VW-1:0] r_mem [DEPTH];
    logic [VW-1:0] r_rdata;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_tgt, n_tgt;
    logic [SW-1:0] r_status, n_status;
    logic          r_valid, n_valid;
    logic [FW-1:0] r_func;
    logic [PW-1:0] r_pos;
    logic [VW-1:0] r_val;
    logic [VW-1:0] r_front, r_back;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [VW-1:0] wr_data;

    logic          do_put, do_take;
    logic [XW-1:0] tgt;
    logic [XW-1:0] cnt_x;

    assign cnt_x = XW'(r_cnt);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_tgt    = r_tgt;
        n_status = r_status;
        n_valid  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_rdata;
        do_put   = 1'b0;
        do_take  = 1'b0;
        tgt      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_IGNORED;
                n_state  = S_FRONT_RD;
                unique case (r_func)
                    FN_PUSH_BACK: begin
                        do_put = 1'b1;
                        tgt    = cnt_x;
                    end
                    FN_PUSH_FRONT: begin
                        do_put = 1'b1;
                    end
                    FN_INSERT: begin
                        do_put = 1'b1;
                        tgt    = XW'(r_pos);
                    end
                    FN_POP_BACK: begin
                        do_take = (r_cnt != '0);
                        tgt     = cnt_x - XW'(1);
                    end
                    FN_POP_FRONT: begin
                        do_take = 1'b1;
                    end
                    FN_REMOVE_AT: begin
                        do_take = 1'b1;
                        tgt     = XW'(r_pos);
                    end
                    FN_REMOVE_VAL: begin
                        if (r_cnt != '0) begin
                            n_idx   = '0;
                            n_state = S_FIND_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PUT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx - AW'(1);
                n_state = S_PUT_WR;
            end
            S_PUT_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                n_idx   = r_idx - AW'(1);
                n_state = ((r_idx - AW'(1)) == r_tgt) ? S_PUT_LAST : S_PUT_RD;
            end
            S_PUT_LAST: begin
                wr_en    = 1'b1;
                wr_addr  = r_tgt;
                wr_data  = r_val;
                n_cnt    = r_cnt + CW'(1);
                n_status = ST_DONE;
                n_state  = S_FRONT_RD;
            end
            S_TAKE_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + AW'(1);
                n_state = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                n_idx   = r_idx + AW'(1);
                if ((CW'(r_idx) + CW'(2)) == r_cnt) begin
                    n_cnt    = r_cnt - CW'(1);
                    n_status = ST_DONE;
                    n_state  = S_FRONT_RD;
                end else begin
                    n_state = S_TAKE_RD;
                end
            end
            S_FIND_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (r_rdata == r_val) begin
                    do_take = 1'b1;
                    tgt     = XW'(r_idx);
                end else if ((CW'(r_idx) + CW'(1)) == r_cnt) begin
                    n_status = ST_IGNORED;
                    n_state  = S_FRONT_RD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_FIND_RD;
                end
            end
            S_FRONT_RD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_BACK_RD;
            end
            S_BACK_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_cnt - CW'(1));
                n_state = S_OUT;
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_put) begin
            if (tgt > cnt_x) begin
                n_status = ST_IGNORED;
                n_state  = S_FRONT_RD;
            end else if (r_cnt == CW'(DEPTH)) begin
                n_status = ST_FULL;
                n_state  = S_FRONT_RD;
            end else begin
                n_tgt   = AW'(tgt);
                n_idx   = AW'(r_cnt);
                n_state = (tgt == cnt_x) ? S_PUT_LAST : S_PUT_RD;
            end
        end

        if (do_take) begin
            if (tgt >= cnt_x) begin
                n_status = ST_IGNORED;
                n_state  = S_FRONT_RD;
            end else begin
                n_idx = AW'(tgt);
                if ((tgt + XW'(1)) == cnt_x) begin
                    n_cnt    = r_cnt - CW'(1);
                    n_status = ST_DONE;
                    n_state  = S_FRONT_RD;
                end else begin
                    n_state = S_TAKE_RD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        if (r_state == S_IDLE && start) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_val  <= i_item_value;
        end
        if (r_state == S_BACK_RD) begin
            r_front <= (r_cnt == '0) ? '0 : r_rdata;
        end
        if (r_state == S_OUT) begin
            r_back <= (r_cnt == '0) ? '0 : r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_count       = r_cnt;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;

endmodule

>>> rtl/isq_checker.sv
// ----------------------------------------------------------------------------
// Indexed sequence store checker
// Port-level properties of the store, attached to the store by a bind.
// ----------------------------------------------------------------------------
module isq_checker
    import isq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 o_valid,
    input  logic [SW-1:0]        o_status,
    input  logic [CW-1:0]        o_count,
    input  logic signed [VW-1:0] o_front_value,
    input  logic signed [VW-1:0] o_back_value
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted beat");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CW'(DEPTH)))
        else $error("count above depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == CW'(DEPTH)))
        else $error("full status while not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count == '0) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("nonzero front or back on an empty store");

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Indexed sequence store testbench
// Sends directed and random operation beats to the store through its
// start/busy handshake and mirrors every accepted beat in a local copy of
// the sequence. Each result beat is checked field by field against the
// oldest predicted report. Random beats alternate between filling and
// draining stretches so that the full and empty cases both come up often.
// ----------------------------------------------------------------------------
module tb;
    import isq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FW-1:0] FN_UNUSED = 3'd7;
    localparam int RANDOM_OPS = 400;
    localparam int TAIL_OPS   = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [FW-1:0]        func;
        logic [PW-1:0]        position;
        logic signed [VW-1:0] value;
    } store_op_t;

    typedef struct packed {
        logic [SW-1:0]        status;
        logic [CW-1:0]        count;
        logic signed [VW-1:0] front;
        logic signed [VW-1:0] back;
    } store_report_t;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FW-1:0]        i_func = '0;
    logic [PW-1:0]        i_position = '0;
    logic signed [VW-1:0] i_item_value = '0;
    logic                 o_valid;
    logic [SW-1:0]        o_status;
    logic [CW-1:0]        o_count;
    logic signed [VW-1:0] o_front_value;
    logic signed [VW-1:0] o_back_value;

    store_op_t     ops_to_send[$];
    store_report_t reports_due[$];
    logic signed [VW-1:0] mirror_entries[DEPTH];
    int            mirror_count = 0;
    int            ops_total = 0;
    int            ops_accepted = 0;
    int            idle_left = 0;
    int            stall_cycles = 0;
    int            mismatches = 0;

    indexed_sequence_store u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [SW-1:0] mirror_place(int at, logic signed [VW-1:0] v);
        if (at > mirror_count) return ST_IGNORED;
        if (mirror_count >= DEPTH) return ST_FULL;
        for (int k = mirror_count; k > at; k--) mirror_entries[k] = mirror_entries[k-1];
        mirror_entries[at] = v;
        mirror_count++;
        return ST_DONE;
    endfunction

    function automatic logic [SW-1:0] mirror_take(int at);
        if (at >= mirror_count) return ST_IGNORED;
        for (int k = at; k + 1 < mirror_count; k++) mirror_entries[k] = mirror_entries[k+1];
        mirror_count--;
        return ST_DONE;
    endfunction

    function automatic store_report_t store_step(store_op_t op);
        store_report_t rep;
        logic [SW-1:0] st;
        case (op.func)
            FN_PUSH_BACK: begin
                st = mirror_place(mirror_count, op.value);
            end
            FN_PUSH_FRONT: begin
                st = mirror_place(0, op.value);
            end
            FN_POP_BACK: begin
                st = (mirror_count != 0) ? mirror_take(mirror_count - 1) : ST_IGNORED;
            end
            FN_POP_FRONT: begin
                st = mirror_take(0);
            end
            FN_INSERT: begin
                st = mirror_place(int'(op.position), op.value);
            end
            FN_REMOVE_AT: begin
                st = mirror_take(int'(op.position));
            end
            FN_REMOVE_VAL: begin
                st = ST_IGNORED;
                for (int k = 0; k < mirror_count; k++) begin
                    if (mirror_entries[k] == op.value) begin
                        st = mirror_take(k);
                        break;
                    end
                end
            end
            default: begin
                st = ST_IGNORED;
            end
        endcase
        rep.status = st;
        rep.count  = CW'(mirror_count);
        rep.front  = (mirror_count != 0) ? mirror_entries[0] : '0;
        rep.back   = (mirror_count != 0) ? mirror_entries[mirror_count-1] : '0;
        return rep;
    endfunction

    function automatic void queue_op(logic [FW-1:0] f, logic [PW-1:0] p,
                                     logic signed [VW-1:0] v);
        store_op_t op;
        op.func     = f;
        op.position = p;
        op.value    = v;
        ops_to_send.insert(ops_to_send.size(), op);
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : drive
        store_op_t taken;
        store_op_t upcoming;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                taken.func     = i_func;
                taken.position = i_position;
                taken.value    = i_item_value;
                reports_due.insert(reports_due.size(), store_step(taken));
                ops_accepted <= ops_accepted + 1;
                if (ops_to_send.size() > TAIL_OPS && $urandom_range(0, 4) == 0)
                    idle_left = $urandom_range(1, 18);
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (ops_to_send.size() != 0) begin
                    upcoming = ops_to_send[0];
                    ops_to_send.delete(0);
                    i_func       <= upcoming.func;
                    i_position   <= upcoming.position;
                    i_item_value <= upcoming.value;
                    start        <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check
        store_report_t want;
        if (i_rst_n && o_valid) begin
            if (reports_due.size() == 0) begin
                report_mismatch("result beat with no operation outstanding");
            end else begin
                want = reports_due[0];
                reports_due.delete(0);
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                if (o_count !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              o_count, want.count));
                if (o_front_value !== want.front)
                    report_mismatch($sformatf("front got %0d want %0d",
                                              o_front_value, want.front));
                if (o_back_value !== want.back)
                    report_mismatch($sformatf("back got %0d want %0d",
                                              o_back_value, want.back));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [FW-1:0]        f;
        logic [PW-1:0]        p;
        logic signed [VW-1:0] v;
        int                   pick;
        bit                   filling;

        // Empty store cases, then edge values and range checks on a short list.
        queue_op(FN_POP_BACK,   5'd0,  32'sd0);
        queue_op(FN_POP_FRONT,  5'd0,  32'sd0);
        queue_op(FN_REMOVE_AT,  5'd0,  32'sd0);
        queue_op(FN_REMOVE_VAL, 5'd0,  32'sd0);
        queue_op(FN_UNUSED,     5'd31, 32'sd7);
        queue_op(FN_PUSH_BACK,  5'd0,  32'h8000_0000);
        queue_op(FN_PUSH_FRONT, 5'd0,  32'h7fff_ffff);
        queue_op(FN_INSERT,     5'd1,  -32'sd1);
        queue_op(FN_INSERT,     5'd31, 32'sd9);
        queue_op(FN_INSERT,     5'd4,  32'sd9);
        queue_op(FN_INSERT,     5'd3,  32'h1234_5678);
        queue_op(FN_REMOVE_AT,  5'd4,  32'sd0);
        queue_op(FN_REMOVE_AT,  5'd16, 32'sd0);
        queue_op(FN_REMOVE_VAL, 5'd0,  32'sd5);
        queue_op(FN_REMOVE_VAL, 5'd0,  -32'sd1);
        queue_op(FN_UNUSED,     5'd0,  32'sd0);
        queue_op(FN_REMOVE_AT,  5'd1,  32'sd0);
        queue_op(FN_POP_BACK,   5'd0,  32'sd0);
        queue_op(FN_POP_FRONT,  5'd0,  32'sd0);
        queue_op(FN_POP_FRONT,  5'd0,  32'sd0);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            filling = ((n / 40) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (filling) begin
                if (pick < 30)      f = FN_PUSH_BACK;
                else if (pick < 50) f = FN_PUSH_FRONT;
                else if (pick < 80) f = FN_INSERT;
                else if (pick < 86) f = FN_POP_BACK;
                else if (pick < 91) f = FN_POP_FRONT;
                else if (pick < 95) f = FN_REMOVE_AT;
                else if (pick < 98) f = FN_REMOVE_VAL;
                else                f = FN_UNUSED;
            end else begin
                if (pick < 5)       f = FN_PUSH_BACK;
                else if (pick < 10) f = FN_PUSH_FRONT;
                else if (pick < 15) f = FN_INSERT;
                else if (pick < 35) f = FN_POP_BACK;
                else if (pick < 55) f = FN_POP_FRONT;
                else if (pick < 75) f = FN_REMOVE_AT;
                else if (pick < 97) f = FN_REMOVE_VAL;
                else                f = FN_UNUSED;
            end
            if ($urandom_range(0, 6) == 0) p = PW'($urandom_range(0, 31));
            else                           p = PW'($urandom_range(0, 16));
            case ($urandom_range(0, 15))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = -32'sd1;
                3:       v = 32'sd0;
                4, 5, 6, 7: v = $urandom_range(1, 4);
                default: v = $urandom;
            endcase
            queue_op(f, p, v);
        end
        ops_total = ops_to_send.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted != ops_total) @(posedge i_clk);
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/isq_pkg.sv
rtl/indexed_sequence_store.sv
rtl/isq_checker.sv
tb/tb.sv
